@@ rtl/id3_pkg.sv @@
package id3_pkg;

  localparam int unsigned HEADER_BYTES = 10;
  localparam int unsigned FIELD_W = 4;
  localparam int unsigned POS_W = 33;

  localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(HEADER_BYTES - 1);
  localparam logic [FIELD_W-1:0] TAG_MAJOR_IDX = 4'd3;
  localparam logic [FIELD_W-1:0] TAG_MINOR_IDX = 4'd4;
  localparam logic [FIELD_W-1:0] TAG_SIZE_IDX = 4'd6;
  localparam logic [FIELD_W-1:0] NAME_END_IDX = 4'd4;
  localparam logic [FIELD_W-1:0] SIZE_END_IDX = 4'd8;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] HEADER_LEN = POS_W'(HEADER_BYTES);

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic CFG_SHOW_ALL = 1'b0;
  localparam logic CFG_WANTED_NAME = 1'b1;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_FRAME,
    PH_PAYLOAD,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [31:0] frame_id;
    logic [31:0] frame_length;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
  } out_req_t;

endpackage

@@ rtl/id3_parse_core.sv @@
module id3_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  id3_pkg::in_req_t   in_req,
  input  logic               show_all,
  input  logic [31:0]        wanted_name,
  output logic               res_valid,
  output id3_pkg::out_req_t  res
);
  import id3_pkg::*;

  phase_t               phase_r, phase_nxt, phase_e;
  logic [FIELD_W-1:0]   field_idx_r, field_idx_nxt, field_idx_e;
  logic [POS_W-1:0]     file_pos_r, file_pos_nxt, pos_e;
  logic [31:0]          tag_len_r, tag_len_nxt;
  logic [31:0]          cur_id_r, cur_id_nxt;
  logic [31:0]          cur_len_r, cur_len_nxt;
  logic [31:0]          bytes_left_r, bytes_left_nxt;
  logic [15:0]          versions_r, versions_nxt;
  logic [7:0]           b;
  logic                 hit;

  always_comb begin
    b = in_req.data_byte;
    phase_e = in_req.start_of_file ? PH_TAG : phase_r;
    field_idx_e = in_req.start_of_file ? '0 : field_idx_r;
    pos_e = in_req.start_of_file ? '0 : file_pos_r;

    phase_nxt = phase_e;
    field_idx_nxt = field_idx_e;
    file_pos_nxt = (pos_e == POS_MAX) ? pos_e : pos_e + 1'b1;
    tag_len_nxt = tag_len_r;
    cur_id_nxt = cur_id_r;
    cur_len_nxt = cur_len_r;
    bytes_left_nxt = bytes_left_r;
    versions_nxt = versions_r;
    hit = 1'b0;

    res_valid = 1'b0;
    res = '0;

    case (phase_e)
      PH_TAG: begin
        if (field_idx_e == TAG_MAJOR_IDX) begin
          versions_nxt[15:8] = b;
        end else if (field_idx_e == TAG_MINOR_IDX) begin
          versions_nxt[7:0] = b;
        end else if (field_idx_e >= TAG_SIZE_IDX) begin
          tag_len_nxt = {tag_len_r[23:0], b};
        end
        if (field_idx_e >= LAST_FIELD) begin
          res_valid = 1'b1;
          res.kind = KIND_HEADER;
          res.version_major = versions_nxt[15:8];
          res.version_minor = versions_nxt[7:0];
          phase_nxt = PH_FRAME;
          field_idx_nxt = '0;
        end else begin
          field_idx_nxt = field_idx_e + 1'b1;
        end
      end
      PH_FRAME: begin
        if (field_idx_e == '0 &&
            (pos_e >= {1'b0, tag_len_r} + HEADER_LEN || b == 8'd0)) begin
          phase_nxt = PH_DONE;
        end else begin
          if (field_idx_e < NAME_END_IDX) begin
            cur_id_nxt = {cur_id_r[23:0], b};
          end else if (field_idx_e < SIZE_END_IDX) begin
            cur_len_nxt = {cur_len_r[23:0], b};
          end
          if (field_idx_e >= LAST_FIELD) begin
            hit = show_all || (cur_id_nxt == wanted_name);
            field_idx_nxt = '0;
            bytes_left_nxt = cur_len_nxt;
            if (hit) begin
              res_valid = 1'b1;
              res.kind = KIND_FRAME;
              res.frame_id = cur_id_nxt;
              res.frame_length = cur_len_nxt;
              res.last_of_frame = (cur_len_nxt == '0);
              if (cur_len_nxt != '0) begin
                phase_nxt = PH_PAYLOAD;
              end else if (!show_all) begin
                phase_nxt = PH_DONE;
              end
            end else if (cur_len_nxt != '0) begin
              phase_nxt = PH_SKIP;
            end
          end else begin
            field_idx_nxt = field_idx_e + 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left_nxt = bytes_left_r - 1'b1;
        res_valid = 1'b1;
        res.kind = KIND_PAYLOAD;
        res.frame_id = cur_id_r;
        res.frame_length = cur_len_r;
        res.payload_byte = b;
        res.last_of_frame = (bytes_left_nxt == '0);
        if (bytes_left_nxt == '0) begin
          phase_nxt = show_all ? PH_FRAME : PH_DONE;
        end
      end
      PH_SKIP: begin
        bytes_left_nxt = bytes_left_r - 1'b1;
        if (bytes_left_nxt == '0) begin
          phase_nxt = PH_FRAME;
        end
      end
      default: begin
        phase_nxt = phase_e;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      field_idx_r <= '0;
      file_pos_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      field_idx_r <= field_idx_nxt;
      file_pos_r <= file_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tag_len_r <= tag_len_nxt;
      cur_id_r <= cur_id_nxt;
      cur_len_r <= cur_len_nxt;
      bytes_left_r <= bytes_left_nxt;
      versions_r <= versions_nxt;
    end
  end

endmodule

@@ rtl/id3_tag_frame_extractor_unit.sv @@
// Byte-serial tag frame parser. Feed a file one byte per request, with
// start_of_file set on its first byte. The 10-byte tag header produces one
// header result with the version bytes; each reported frame produces a frame
// start result followed by one result per payload byte, last_of_frame marking
// the final one (or an empty frame). With show_all cleared only the first frame
// whose name equals wanted_name is reported. The parser state updates in the
// accepting cycle and the result lands in a single output register, so a new
// byte is taken every cycle while the output side keeps up; input ready drops
// only while that register holds a result that has not been taken.
// Configuration must be written while no bytes are in flight.
module id3_tag_frame_extractor_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  id3_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output id3_pkg::out_req_t  out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import id3_pkg::*;

  logic      show_all_r;
  logic [31:0] wanted_name_r;
  logic      out_valid_r, out_valid_nxt;
  out_req_t  out_data_r;
  logic      step;
  logic      res_valid;
  out_req_t  res;

  assign in_ready = !out_valid_r || out_ready;
  assign step = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_all_r <= 1'b1;
      wanted_name_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SHOW_ALL: show_all_r <= cfg_data[0];
        CFG_WANTED_NAME: wanted_name_r <= cfg_data;
        default: show_all_r <= show_all_r;
      endcase
    end
  end

  id3_parse_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .in_req      (in_data),
    .show_all    (show_all_r),
    .wanted_name (wanted_name_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind != KIND_UNUSED)
    else $error("result kind out of range");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_HEADER |->
      out_data.frame_id == '0 && out_data.frame_length == '0 &&
      out_data.payload_byte == '0 && !out_data.last_of_frame)
    else $error("header result carries frame fields");

  a_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_PAYLOAD |-> out_data.payload_byte == '0)
    else $error("payload byte outside payload result");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result lost");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import id3_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned BYTES_PER_PHASE = 75;

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_req_t out_data;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = CFG_SHOW_ALL;
  logic [31:0] cfg_data = '0;

  // parser shadow state
  phase_t parse_phase = PH_TAG;
  logic [FIELD_W-1:0] field_idx = '0;
  logic [31:0] tag_len = '0;
  logic [POS_W-1:0] file_pos = '0;
  logic [31:0] frame_name = '0;
  logic [31:0] frame_len = '0;
  logic [31:0] remaining = '0;
  logic [7:0] ver_major = '0;
  logic [7:0] ver_minor = '0;
  logic show_all_cfg = 1'b1;
  logic [31:0] wanted_cfg = '0;

  in_req_t bytes_to_send[$];
  in_req_t draft[$];
  out_req_t results_due[$];
  logic [31:0] name_pool[5];

  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  int unsigned out_draw;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned queued_total = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;

  id3_tag_frame_extractor_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50) begin
      $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic parse_byte(input in_req_t r);
    logic [POS_W-1:0] at;
    logic hit;
    logic emit;
    out_req_t res;
    if (r.start_of_file) begin
      parse_phase = PH_TAG;
      field_idx = '0;
      tag_len = '0;
      file_pos = '0;
      frame_name = '0;
      frame_len = '0;
      remaining = '0;
      ver_major = '0;
      ver_minor = '0;
    end
    at = file_pos;
    if (file_pos != POS_MAX) file_pos = file_pos + 1'b1;
    emit = 1'b0;
    res = '0;
    case (parse_phase)
      PH_TAG: begin
        if (field_idx == TAG_MAJOR_IDX) ver_major = r.data_byte;
        else if (field_idx == TAG_MINOR_IDX) ver_minor = r.data_byte;
        else if (field_idx >= TAG_SIZE_IDX) tag_len = {tag_len[23:0], r.data_byte};
        if (field_idx >= LAST_FIELD) begin
          res.kind = KIND_HEADER;
          res.version_major = ver_major;
          res.version_minor = ver_minor;
          emit = 1'b1;
          parse_phase = PH_FRAME;
          field_idx = '0;
        end else begin
          field_idx = field_idx + 1'b1;
        end
      end
      PH_FRAME: begin
        if (field_idx == '0 && ({1'b0, at} >= {2'b00, tag_len} + {1'b0, HEADER_LEN} ||
            r.data_byte == 8'h00)) begin
          parse_phase = PH_DONE;
        end else begin
          if (field_idx < NAME_END_IDX) frame_name = {frame_name[23:0], r.data_byte};
          else if (field_idx < SIZE_END_IDX) frame_len = {frame_len[23:0], r.data_byte};
          if (field_idx >= LAST_FIELD) begin
            hit = show_all_cfg || frame_name == wanted_cfg;
            field_idx = '0;
            remaining = frame_len;
            if (hit) begin
              res.kind = KIND_FRAME;
              res.frame_id = frame_name;
              res.frame_length = frame_len;
              res.last_of_frame = (frame_len == 32'd0);
              emit = 1'b1;
              if (frame_len != 32'd0) parse_phase = PH_PAYLOAD;
              else if (!show_all_cfg) parse_phase = PH_DONE;
            end else if (frame_len != 32'd0) begin
              parse_phase = PH_SKIP;
            end
          end else begin
            field_idx = field_idx + 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        remaining = remaining - 1;
        res.kind = KIND_PAYLOAD;
        res.frame_id = frame_name;
        res.frame_length = frame_len;
        res.payload_byte = r.data_byte;
        res.last_of_frame = (remaining == 32'd0);
        emit = 1'b1;
        if (remaining == 32'd0) parse_phase = show_all_cfg ? PH_FRAME : PH_DONE;
      end
      PH_SKIP: begin
        remaining = remaining - 1;
        if (remaining == 32'd0) parse_phase = PH_FRAME;
      end
      default: begin
      end
    endcase
    if (emit) results_due.push_back(res);
  endtask

  task automatic check_result(input out_req_t got);
    out_req_t want;
    if (results_due.size() == 0) begin
      report_mismatch("unexpected result, kind", 32'(got.kind), 32'd0);
      return;
    end
    want = results_due.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
    if (got.version_major !== want.version_major)
      report_mismatch("version_major", 32'(got.version_major), 32'(want.version_major));
    if (got.version_minor !== want.version_minor)
      report_mismatch("version_minor", 32'(got.version_minor), 32'(want.version_minor));
    if (got.frame_id !== want.frame_id)
      report_mismatch("frame_id", got.frame_id, want.frame_id);
    if (got.frame_length !== want.frame_length)
      report_mismatch("frame_length", got.frame_length, want.frame_length);
    if (got.payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
    if (got.last_of_frame !== want.last_of_frame)
      report_mismatch("last_of_frame", 32'(got.last_of_frame), 32'(want.last_of_frame));
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) parse_byte(in_data);
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (bytes_to_send.size() != 0) begin
        in_data <= bytes_to_send.pop_front();
        in_valid <= 1'b1;
        in_gap <= quiet_in ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (out_hold != 0) begin
        out_ready <= 1'b0;
        out_hold <= out_hold - 1;
      end else if (out_valid && out_ready && !quiet_out) begin
        out_draw = $urandom_range(0, 8);
        out_ready <= (out_draw == 0);
        out_hold <= (out_draw == 0) ? 0 : out_draw - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic sof);
    in_req_t r;
    r.data_byte = b;
    r.start_of_file = sof;
    bytes_to_send.push_back(r);
    queued_total++;
  endtask

  task automatic draft_byte(input logic [7:0] b);
    in_req_t r;
    r.data_byte = b;
    r.start_of_file = (draft.size() == 0);
    draft.push_back(r);
  endtask

  task automatic draft_word(input logic [31:0] w);
    draft_byte(w[31:24]);
    draft_byte(w[23:16]);
    draft_byte(w[15:8]);
    draft_byte(w[7:0]);
  endtask

  function automatic logic [31:0] pick_name();
    if ($urandom_range(0, 3) != 0) return name_pool[$urandom_range(0, 4)];
    return $urandom;
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SHOW_ALL) show_all_cfg = val[0];
    else wanted_cfg = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle(input int unsigned settle);
    while (bytes_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // one tag: header, a few frames, then padding or junk; sometimes cut short
  task automatic build_file();
    int unsigned frame_cnt;
    int unsigned total;
    int unsigned pad_cnt;
    int unsigned keep;
    int unsigned body;
    logic [31:0] names[4];
    logic [31:0] sizes[4];
    logic [31:0] tag_size;
    bit abort_last;
    draft.delete();
    frame_cnt = $urandom_range(0, 4);
    abort_last = frame_cnt != 0 && $urandom_range(0, 9) == 0;
    total = 0;
    for (int i = 0; i < frame_cnt; i++) begin
      names[i] = pick_name();
      sizes[i] = $urandom_range(0, 6);
      total += HEADER_BYTES + sizes[i];
    end
    if (abort_last) sizes[frame_cnt-1] = $urandom | 32'h0000_0100;
    pad_cnt = $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0, 1: tag_size = total + pad_cnt;
      2: tag_size = $urandom_range(0, total);
      default: tag_size = $urandom;
    endcase
    if ($urandom_range(0, 3) != 0) begin
      draft_byte(8'h49);
      draft_byte(8'h44);
      draft_byte(8'h33);
    end else begin
      draft_byte(8'($urandom));
      draft_byte(8'($urandom));
      draft_byte(8'($urandom));
    end
    draft_byte(8'($urandom));
    draft_byte(8'($urandom));
    draft_byte(8'($urandom));
    draft_word(tag_size);
    for (int i = 0; i < frame_cnt; i++) begin
      draft_word(names[i]);
      draft_word(sizes[i]);
      draft_byte(8'($urandom));
      draft_byte(8'($urandom));
      body = (abort_last && i == frame_cnt - 1) ? $urandom_range(0, 5) : sizes[i];
      for (int k = 0; k < body; k++) draft_byte(8'($urandom));
    end
    if (!abort_last) begin
      for (int i = 0; i < pad_cnt; i++) draft_byte(8'h00);
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < $urandom_range(1, 3); i++) draft_byte(8'($urandom));
      end
    end
    keep = draft.size();
    if ($urandom_range(0, 7) == 0) keep = $urandom_range(1, draft.size());
    for (int i = 0; i < keep; i++) queue_byte(draft[i].data_byte, draft[i].start_of_file);
  endtask

  task automatic add_noise();
    for (int i = 0; i < $urandom_range(1, 12); i++)
      queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [7:0] dir_bytes[$];
    logic mode;
    logic [31:0] name_sel;
    int unsigned phase_start;
    name_pool[0] = 32'h5449_5432;
    name_pool[1] = 32'h5441_4C42;
    name_pool[2] = 32'h5450_4531;
    name_pool[3] = 32'hFFFF_FFFF;
    name_pool[4] = 32'h434F_4D4D;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // tag size zero stops at the first frame byte, then one more ignored byte;
    // second tag: one-byte frame, empty frame with all-ones name, padding, junk
    dir_bytes = '{8'h49, 8'h44, 8'h33, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h54, 8'h58,
                  8'h49, 8'h44, 8'h33, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20,
                  8'h54, 8'h49, 8'h54, 8'h32, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                  8'hA5,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                  8'h00, 8'h55};
    @(posedge clk);
    foreach (dir_bytes[i]) queue_byte(dir_bytes[i], i == 0 || i == 12);
    wait_idle(4);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          mode = 1'b1;
          name_sel = 32'h0000_0000;
        end
        1: begin
          mode = 1'b0;
          name_sel = 32'hFFFF_FFFF;
        end
        2: begin
          mode = 1'b0;
          name_sel = 32'h0000_0000;
        end
        default: begin
          mode = 1'($urandom_range(0, 1));
          name_sel = $urandom_range(0, 7) == 0 ? $urandom : name_pool[$urandom_range(0, 4)];
        end
      endcase
      write_reg(CFG_SHOW_ALL, {$urandom_range(0, 1) == 0 ? 31'd0 : 31'($urandom), mode});
      write_reg(CFG_WANTED_NAME, name_sel);
      quiet_in = $urandom_range(0, 3) == 0;
      quiet_out = $urandom_range(0, 3) == 0;
      @(posedge clk);
      phase_start = queued_total;
      while (queued_total - phase_start < BYTES_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        else build_file();
      end
      wait_idle(4);
    end

    wait_idle(8);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
